// ----- hw/rtl/rhnd_pkg.sv -----
`default_nettype none

package rhnd_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_NORMAL      = 2'd0,
		ST_END_MARKER  = 2'd1,
		ST_UNSUPPORTED = 2'd2,
		ST_TRUNCATED   = 2'd3
	} status_t;

	// rtp and nal header constants
	localparam logic [18:0] RTP_FIXED_LEN  = 19'd12;
	localparam logic [4:0]  NAL_FU_A       = 5'd28;
	localparam logic [4:0]  NAL_VCL_MAX    = 5'd5;
	localparam logic [4:0]  NAL_SINGLE_MAX = 5'd23;
	localparam int          FU_START_BIT   = 7;

	// commands from the controller to the datapath
	typedef struct packed {
		logic pkt_byte;
		logic tbl_wr;
		logic clr_wr;
		logic rd_en;
		logic addr_clr;
		logic addr_inc;
		logic acc_clr;
		logic out_load;
	} rhnd_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rhnd_parser.sv -----
`default_nettype none

module rhnd_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rhnd_pkg::rhnd_cmd_t cmd,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last_byte,
	output logic                   need_match,
	output rhnd_pkg::status_t      status_q,
	output logic [31:0]            nal_counter_q
);

	typedef enum logic [2:0] {
		PH_FIXED   = 3'd0,
		PH_EXTHDR  = 3'd1,
		PH_NALHDR  = 3'd2,
		PH_FUHDR   = 3'd3,
		PH_DONE    = 3'd4,
		PH_EXTBODY = 3'd5,
		PH_EXTLEN  = 3'd6
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [16:0] idx_q;
	logic [18:0] hl_q, hl_n, hl_fixed;
	logic        ext_q, ext_n;
	logic [4:0]  pt_q, pt_n;
	logic [31:0] cnt_n;
	logic        bump;
	logic [18:0] idx_p1;
	rhnd_pkg::status_t status_d;

	assign idx_p1   = 19'({1'b0, idx_q} + 18'd1);
	assign hl_fixed = rhnd_pkg::RTP_FIXED_LEN + {13'd0, data_byte[3:0], 2'b00};

	// header walk for one byte
	always_comb begin
		phase_n = phase_q;
		hl_n    = hl_q;
		ext_n   = ext_q;
		pt_n    = pt_q;
		bump    = 1'b0;
		case (phase_q)
			PH_FIXED: begin
				if (idx_q == 17'd0) begin
					ext_n = data_byte[4];
					hl_n  = hl_fixed;
				end
				if (idx_p1 == hl_n) begin
					phase_n = ext_n ? PH_EXTHDR : PH_NALHDR;
				end
			end
			PH_EXTHDR: begin
				if ({3'd0, idx_q} == ({1'b0, hl_q} + 20'd2)) begin
					hl_n    = hl_q + {1'b0, data_byte, 10'd0};
					phase_n = PH_EXTLEN;
				end
			end
			PH_EXTLEN: begin
				hl_n    = hl_q + {9'd0, data_byte, 2'b00} + 19'd4;
				phase_n = PH_EXTBODY;
				if (idx_p1 == hl_n) begin
					phase_n = PH_NALHDR;
				end
			end
			PH_EXTBODY: begin
				if (idx_p1 == hl_q) begin
					phase_n = PH_NALHDR;
				end
			end
			PH_NALHDR: begin
				pt_n = data_byte[4:0];
				if (pt_n == rhnd_pkg::NAL_FU_A) begin
					phase_n = PH_FUHDR;
				end else begin
					bump    = (pt_n != 5'd0) && (pt_n <= rhnd_pkg::NAL_VCL_MAX);
					phase_n = PH_DONE;
				end
			end
			PH_FUHDR: begin
				bump = data_byte[rhnd_pkg::FU_START_BIT] && (data_byte[4:0] != 5'd0)
					&& (data_byte[4:0] <= rhnd_pkg::NAL_VCL_MAX);
				phase_n = PH_DONE;
			end
			default: begin
			end
		endcase
	end

	// saturating nal counter
	assign cnt_n = (bump && (nal_counter_q != 32'hFFFF_FFFF)) ?
		nal_counter_q + 32'd1 : nal_counter_q;

	// packet status at its final byte
	always_comb begin
		if (phase_n == PH_NALHDR) begin
			status_d = rhnd_pkg::ST_END_MARKER;
		end else if (phase_n == PH_DONE) begin
			if (((pt_n != 5'd0) && (pt_n <= rhnd_pkg::NAL_SINGLE_MAX))
					|| (pt_n == rhnd_pkg::NAL_FU_A)) begin
				status_d = rhnd_pkg::ST_NORMAL;
			end else begin
				status_d = rhnd_pkg::ST_UNSUPPORTED;
			end
		end else begin
			status_d = rhnd_pkg::ST_TRUNCATED;
		end
	end

	assign need_match = (status_d == rhnd_pkg::ST_NORMAL);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_FIXED;
			idx_q         <= 17'd0;
			hl_q          <= rhnd_pkg::RTP_FIXED_LEN;
			ext_q         <= 1'b0;
			pt_q          <= 5'd0;
			nal_counter_q <= 32'd0;
			status_q      <= rhnd_pkg::ST_NORMAL;
		end else if (cmd.pkt_byte) begin
			nal_counter_q <= cnt_n;
			if (last_byte) begin
				status_q <= status_d;
				phase_q  <= PH_FIXED;
				idx_q    <= 17'd0;
				hl_q     <= rhnd_pkg::RTP_FIXED_LEN;
				ext_q    <= 1'b0;
				pt_q     <= 5'd0;
			end else begin
				phase_q <= phase_n;
				hl_q    <= hl_n;
				ext_q   <= ext_n;
				pt_q    <= pt_n;
				if (idx_q != 17'h1FFFF) begin
					idx_q <= idx_q + 17'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rhnd_drop_table.sv -----
`default_nettype none

module rhnd_drop_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rhnd_pkg::rhnd_cmd_t cmd,
	input  wire logic [5:0]        entry_index,
	input  wire logic [31:0]       entry_value,
	input  wire logic              entry_valid,
	input  wire logic [31:0]       nal_counter,
	output logic                   addr_last,
	output logic                   hit_q
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int XW = (IW > 6) ? IW : 6;

	logic [32:0]   mem [TABLE_DEPTH];
	logic [IW-1:0] addr_q;
	logic [XW-1:0] slot_ext;
	logic          slot_ok;
	logic          we;
	logic [IW-1:0] waddr;
	logic [32:0]   wdata;
	logic [32:0]   rd_word_s1;
	logic          rd_valid_s1;

	assign slot_ext  = XW'(entry_index);
	assign slot_ok   = (32'(entry_index) < TABLE_DEPTH);
	assign addr_last = (addr_q == IW'(TABLE_DEPTH - 1));

	// write port: clearing pass or entry load
	assign we    = cmd.clr_wr || (cmd.tbl_wr && slot_ok);
	assign waddr = cmd.clr_wr ? addr_q : slot_ext[IW-1:0];
	assign wdata = cmd.clr_wr ? 33'd0 : {entry_valid, entry_value};

	// table memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_word_s1 <= mem[addr_q];
		end
	end

	// sweep address counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.addr_clr || (cmd.addr_inc && addr_last)) begin
			addr_q <= '0;
		end else if (cmd.addr_inc) begin
			addr_q <= addr_q + IW'(1);
		end
	end

	// match accumulation over the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			if (cmd.acc_clr) begin
				hit_q <= 1'b0;
			end else if (rd_valid_s1 && rd_word_s1[32] && (rd_word_s1[31:0] == nal_counter)) begin
				hit_q <= 1'b1;
			end
		end
	end

	we_not_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !we)
		else $error("table written during scan");

endmodule

`default_nettype wire

// ----- hw/rtl/rhnd_ctrl.sv -----
`default_nettype none

module rhnd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              kind,
	input  wire logic              last_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire logic              need_match,
	input  wire logic              addr_last,
	output rhnd_pkg::rhnd_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_CLEAR  = 3'd0,
		S_IDLE   = 3'd1,
		S_SCAN   = 3'd2,
		S_DRAIN  = 3'd3,
		S_RESULT = 3'd4
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   out_valid_q;
	logic   accept;
	logic   accept_last;
	logic   out_free;

	assign accept      = in_valid && !in_stall_q;
	assign accept_last = accept && !kind && last_byte;
	assign out_free    = !out_valid_q || !out_stall;
	assign in_stall    = in_stall_q;
	assign out_valid   = out_valid_q;

	// datapath commands
	always_comb begin
		cmd          = '0;
		cmd.pkt_byte = accept && !kind;
		cmd.tbl_wr   = accept && kind;
		cmd.clr_wr   = (state_q == S_CLEAR);
		cmd.rd_en    = (state_q == S_SCAN);
		cmd.addr_inc = (state_q == S_CLEAR) || (state_q == S_SCAN);
		cmd.addr_clr = accept_last;
		cmd.acc_clr  = accept_last;
		cmd.out_load = (state_q == S_RESULT) && out_free;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			in_stall_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// output register holds its result until taken
			out_valid_q <= cmd.out_load || (out_valid_q && out_stall);
			case (state_q)
				S_CLEAR: begin
					if (addr_last) begin
						state_q    <= S_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept_last) begin
						in_stall_q <= 1'b1;
						if (need_match) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_RESULT;
						end
					end
				end
				S_SCAN: begin
					if (addr_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q    <= S_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

	result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

	load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not offered");

	direct_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_last && !need_match) |=> (in_stall && !cmd.rd_en))
		else $error("non-matching packet started a scan");

	scan_before_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_last && need_match) |=> (in_stall && cmd.rd_en))
		else $error("table scan did not start");

endmodule

`default_nettype wire

// ----- hw/rtl/rtp_h264_nal_drop_classifier_core.sv -----
// channel   direction  handshake            payload
// request   in         in_valid / in_stall  kind, data_byte, last_byte,
//                                           entry_index, entry_value, entry_valid
// result    out        out_valid / out_stall classify, status, nal_number
//
// one packet byte or one table write per cycle while the input is open
// final byte of a normally parsed packet starts a scan of the drop table, one entry
// per cycle through its single read port; in_stall stays high through the scan, drain
// and result states, and the result enters the output register once that register is free
// any other final byte skips the scan and goes straight to the result state
// after reset a clearing pass over every table entry holds in_stall high
// a result waiting in the output register stalls the input only at the next final byte
`default_nettype none

module rtp_h264_nal_drop_classifier_core #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire logic [5:0]  entry_index,
	input  wire logic [31:0] entry_value,
	input  wire logic        entry_valid,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             classify,
	output logic [1:0]       status,
	output logic [31:0]      nal_number
);

	rhnd_pkg::rhnd_cmd_t cmd;
	rhnd_pkg::status_t   status_q;
	logic                need_match;
	logic                addr_last;
	logic                hit_q;
	logic [31:0]         nal_counter_q;
	logic                res_cls_q;
	rhnd_pkg::status_t   res_status_q;
	logic [31:0]         res_num_q;

	rhnd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.need_match (need_match),
		.addr_last  (addr_last),
		.cmd        (cmd)
	);

	rhnd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.need_match    (need_match),
		.status_q      (status_q),
		.nal_counter_q (nal_counter_q)
	);

	rhnd_drop_table #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.entry_valid (entry_valid),
		.nal_counter (nal_counter_q),
		.addr_last   (addr_last),
		.hit_q       (hit_q)
	);

	// output register, loaded once per packet result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cls_q    <= 1'b0;
			res_status_q <= rhnd_pkg::ST_NORMAL;
			res_num_q    <= 32'd0;
		end else if (cmd.out_load) begin
			res_cls_q    <= hit_q;
			res_status_q <= status_q;
			res_num_q    <= nal_counter_q;
		end
	end

	// result fields
	assign classify   = res_cls_q;
	assign status     = res_status_q;
	assign nal_number = res_num_q;

	no_hit_off_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != rhnd_pkg::ST_NORMAL)) |-> !classify)
		else $error("classify set on a packet that was not parsed normally");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;

	localparam int TABLE_DEPTH = 64;
	localparam int unsigned POS_MAX = 131071;
	localparam int unsigned ITEM_TOTAL = 1850;
	localparam int unsigned CYCLE_LIMIT = 1500000;
	localparam int REPORT_LIMIT = 10;

	// parser position within one packet
	typedef enum logic [2:0] {
		RTP_HDR, EXT_HDR, EXT_LEN, EXT_BODY, NAL_HDR, FU_HDR, TRAILER
	} parse_phase_t;

	typedef struct packed {
		logic              cls;
		rhnd_pkg::status_t st;
		logic [31:0]       num;
	} verdict_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic        last;
		logic [5:0]  slot;
		logic [31:0] num;
		logic        en;
	} request_t;

	// one packet or one drop table write, expanded into requests when sent
	typedef struct packed {
		logic        is_write;
		logic [7:0]  hdr0;
		logic [15:0] ext_words;
		logic [7:0]  nal;
		logic [7:0]  fu;
		int unsigned len;
		logic [5:0]  slot;
		logic [31:0] num;
		logic        en;
		logic        has_exp;
		verdict_t    want;
	} pkt_desc_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        kind = 1'b0;
	logic [7:0]  data_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic [5:0]  entry_index = 6'd0;
	logic [31:0] entry_value = 32'd0;
	logic        entry_valid = 1'b0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic        classify;
	logic [1:0]  status;
	logic [31:0] nal_number;

	// predicted parser and drop table state
	int unsigned  byte_pos;
	int unsigned  hdr_len;
	logic         ext_flag;
	logic [4:0]   nal_type;
	parse_phase_t parse_phase;
	logic [31:0]  nal_count = 32'd0;
	logic [31:0]  drop_num [TABLE_DEPTH];
	logic         drop_en [TABLE_DEPTH] = '{default: 1'b0};

	verdict_t    pending_verdicts [$];
	int          fail_count = 0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	bit          hold_results = 1'b0;

	rtp_h264_nal_drop_classifier_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.entry_valid(entry_valid),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.classify(classify),
		.status(status),
		.nal_number(nal_number)
	);

	always #10 clk = ~clk;

	function automatic void clear_packet();
		byte_pos = 0;
		hdr_len = rhnd_pkg::RTP_FIXED_LEN;
		ext_flag = 1'b0;
		nal_type = 5'd0;
		parse_phase = RTP_HDR;
	endfunction

	function automatic void count_nal_unit();
		if (nal_count != 32'hFFFF_FFFF) begin
			nal_count++;
		end
	endfunction

	function automatic logic drop_hit(input logic [31:0] n);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (drop_en[i] && drop_num[i] == n) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// advance the parser by one request; returns 1 when a result is due
	function automatic bit parse_request(input request_t r, output verdict_t v);
		int unsigned pos;
		int unsigned bv;
		pos = byte_pos;
		bv = r.data;
		v = '{1'b0, rhnd_pkg::ST_NORMAL, 32'd0};
		if (r.kind) begin
			if (r.slot < TABLE_DEPTH) begin
				drop_num[r.slot] = r.num;
				drop_en[r.slot] = r.en;
			end
			return 1'b0;
		end
		case (parse_phase)
			RTP_HDR: begin
				if (pos == 0) begin
					ext_flag = r.data[4];
					hdr_len = rhnd_pkg::RTP_FIXED_LEN + 4 * r.data[3:0];
				end
				if (pos + 1 == hdr_len) begin
					parse_phase = ext_flag ? EXT_HDR : NAL_HDR;
				end
			end
			EXT_HDR: begin
				// high byte of the extension length in words
				if (pos == hdr_len + 2) begin
					hdr_len += bv << 10;
					parse_phase = EXT_LEN;
				end
			end
			EXT_LEN: begin
				hdr_len += (bv << 2) + 4;
				parse_phase = EXT_BODY;
				if (pos + 1 == hdr_len) begin
					parse_phase = NAL_HDR;
				end
			end
			EXT_BODY: begin
				if (pos + 1 == hdr_len) begin
					parse_phase = NAL_HDR;
				end
			end
			NAL_HDR: begin
				nal_type = r.data[4:0];
				if (nal_type == rhnd_pkg::NAL_FU_A) begin
					parse_phase = FU_HDR;
				end else begin
					if (nal_type >= 1 && nal_type <= rhnd_pkg::NAL_VCL_MAX) begin
						count_nal_unit();
					end
					parse_phase = TRAILER;
				end
			end
			FU_HDR: begin
				// only a start fragment of a slice counts
				if (r.data[rhnd_pkg::FU_START_BIT] && r.data[4:0] >= 1
						&& r.data[4:0] <= rhnd_pkg::NAL_VCL_MAX) begin
					count_nal_unit();
				end
				parse_phase = TRAILER;
			end
			default: begin
			end
		endcase
		if (byte_pos < POS_MAX) begin
			byte_pos++;
		end
		if (!r.last) begin
			return 1'b0;
		end
		// final byte: classify the packet
		if (parse_phase == NAL_HDR) begin
			v.st = rhnd_pkg::ST_END_MARKER;
		end else if (parse_phase == TRAILER) begin
			if ((nal_type >= 1 && nal_type <= rhnd_pkg::NAL_SINGLE_MAX)
					|| nal_type == rhnd_pkg::NAL_FU_A) begin
				v.st = rhnd_pkg::ST_NORMAL;
				v.cls = drop_hit(nal_count);
			end else begin
				v.st = rhnd_pkg::ST_UNSUPPORTED;
			end
		end else begin
			v.st = rhnd_pkg::ST_TRUNCATED;
		end
		v.num = nal_count;
		clear_packet();
		return 1'b1;
	endfunction

	function automatic int unsigned rtp_hdr_bytes(input logic [7:0] hdr0, input logic [15:0] ext);
		return rhnd_pkg::RTP_FIXED_LEN + 4 * hdr0[3:0] + (hdr0[4] ? 4 + 4 * ext : 0);
	endfunction

	function automatic pkt_desc_t pkt(input logic [7:0] hdr0, input logic [15:0] ext,
			input logic [7:0] nal, input logic [7:0] fu, input int unsigned len);
		pkt_desc_t d;
		d = '0;
		d.hdr0 = hdr0;
		d.ext_words = ext;
		d.nal = nal;
		d.fu = fu;
		d.len = len;
		return d;
	endfunction

	function automatic pkt_desc_t wr(input logic [5:0] slot, input logic [31:0] num,
			input logic en);
		pkt_desc_t d;
		d = '0;
		d.is_write = 1'b1;
		d.slot = slot;
		d.num = num;
		d.en = en;
		return d;
	endfunction

	function automatic pkt_desc_t with_verdict(input pkt_desc_t d, input logic cls,
			input rhnd_pkg::status_t st, input logic [31:0] num);
		d.has_exp = 1'b1;
		d.want = '{cls, st, num};
		return d;
	endfunction

	// byte i of a packet: header fields at their offsets, random filler elsewhere
	function automatic logic [7:0] packet_byte(input pkt_desc_t d, input int unsigned i);
		int unsigned base;
		int unsigned hl;
		base = rhnd_pkg::RTP_FIXED_LEN + 4 * d.hdr0[3:0];
		hl = rtp_hdr_bytes(d.hdr0, d.ext_words);
		if (i == 0) return d.hdr0;
		if (d.hdr0[4] && i == base + 2) return d.ext_words[15:8];
		if (d.hdr0[4] && i == base + 3) return d.ext_words[7:0];
		if (i == hl) return d.nal;
		if (i == hl + 1) return d.fu;
		return 8'($urandom);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// mostly well-formed packets with random content, some table writes and broken packets
	function automatic pkt_desc_t random_desc();
		logic [7:0]  hdr0;
		logic [15:0] ext;
		logic [4:0]  t;
		logic [7:0]  fu;
		int unsigned hl;
		int unsigned len;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			r = $urandom_range(0, 9);
			return wr(6'($urandom),
				r < 6 ? nal_count + $urandom_range(0, 4) :
				r < 7 ? 32'd0 : r < 8 ? 32'hFFFF_FFFF : $urandom,
				$urandom_range(0, 3) != 0);
		end
		hdr0 = 8'($urandom);
		hdr0[4] = ($urandom_range(0, 99) < 30);
		hdr0[3:0] = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
		ext = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(4, 40)) :
			16'($urandom_range(0, 3));
		r = $urandom_range(0, 99);
		if (r < 45) begin
			t = 5'($urandom_range(1, 5));
		end else if (r < 60) begin
			t = rhnd_pkg::NAL_FU_A;
		end else if (r < 75) begin
			t = 5'($urandom_range(6, rhnd_pkg::NAL_SINGLE_MAX));
		end else begin
			// unsupported types; a draw of 32 wraps to type 0
			t = 5'($urandom_range(24, 32));
			if (t == rhnd_pkg::NAL_FU_A) t = 5'd31;
		end
		fu = ($urandom_range(0, 9) < 7) ?
			{1'b1, 2'($urandom), 5'($urandom_range(1, 5))} : 8'($urandom);
		hl = rtp_hdr_bytes(hdr0, ext);
		if ($urandom_range(0, 99) < 15) begin
			len = $urandom_range(1, hl + 1);
		end else begin
			len = hl + 1 + (t == rhnd_pkg::NAL_FU_A) + $urandom_range(0, 6);
		end
		return pkt(hdr0, ext, {3'($urandom), t}, fu, len);
	endfunction

	// drive one request and hold it until accepted
	task automatic offer(input request_t r, input bit eager);
		int unsigned g;
		g = eager ? 0 : pick_gap();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= r.kind;
		data_byte <= r.data;
		last_byte <= r.last;
		entry_index <= r.slot;
		entry_value <= r.num;
		entry_valid <= r.en;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
	endtask

	task automatic send_desc(input pkt_desc_t d, input bit eager);
		request_t r;
		verdict_t v;
		if (d.is_write) begin
			r = '{1'b1, 8'($urandom), 1'($urandom), d.slot, d.num, d.en};
			offer(r, eager);
			void'(parse_request(r, v));
			items_sent++;
		end else begin
			for (int unsigned i = 0; i < d.len; i++) begin
				r = '{1'b0, packet_byte(d, i), i + 1 == d.len, 6'($urandom), $urandom,
					1'($urandom)};
				offer(r, eager);
				if (parse_request(r, v)) begin
					pending_verdicts = {pending_verdicts, d.has_exp ? d.want : v};
				end
				items_sent++;
			end
		end
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_verdicts.size() != 0);
	endtask

	// stimulus: directed packets first, then random traffic
	initial begin : stimulus
		pkt_desc_t plan [$];
		bit drained;
		int unsigned rand_base;
		drained = 1'b0;
		clear_packet();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		plan = {plan, with_verdict(pkt(8'h80, 16'd0, 8'h00, 8'h00, 1), 1'b0,
			rhnd_pkg::ST_TRUNCATED, 32'd0)};
		plan = {plan, with_verdict(pkt(8'h80, 16'd0, 8'h00, 8'h00, 12), 1'b0,
			rhnd_pkg::ST_END_MARKER, 32'd0)};
		plan = {plan, wr(6'd0, 32'd0, 1'b1)};
		plan = {plan, with_verdict(pkt(8'h80, 16'd0, 8'h06, 8'h00, 13), 1'b1,
			rhnd_pkg::ST_NORMAL, 32'd0)};
		plan = {plan, with_verdict(pkt(8'h80, 16'd0, 8'h00, 8'h00, 14), 1'b0,
			rhnd_pkg::ST_UNSUPPORTED, 32'd0)};
		plan = {plan, wr(6'd63, 32'hFFFF_FFFF, 1'b1)};
		plan = {plan, wr(6'd1, 32'd1, 1'b1)};
		plan = {plan, with_verdict(pkt(8'h80, 16'd0, 8'h65, 8'h00, 20), 1'b1,
			rhnd_pkg::ST_NORMAL, 32'd1)};
		plan = {plan, wr(6'd0, 32'd0, 1'b0)};
		plan = {plan, pkt(8'h8F, 16'd0, 8'h41, 8'h00, 80)};
		plan = {plan, pkt(8'h90, 16'd0, 8'h7C, 8'h85, 30)};
		plan = {plan, pkt(8'hB2, 16'd2, 8'h5C, 8'h05, 40)};
		plan = {plan, pkt(8'h80, 16'd0, 8'h1C, 8'h00, 13)};
		plan = {plan, pkt(8'h80, 16'd0, 8'h3C, 8'h80, 15)};
		plan = {plan, pkt(8'h80, 16'd0, 8'h1C, 8'hC6, 14)};
		// extension length with a nonzero high byte; packet ends inside it
		plan = {plan, pkt(8'h9F, 16'h0101, 8'h21, 8'h00, 120)};
		plan = {plan, pkt(8'h90, 16'd3, 8'h41, 8'h00, 15)};
		plan = {plan, pkt(8'h80, 16'd0, 8'h18, 8'h00, 13)};
		plan = {plan, pkt(8'h80, 16'd0, 8'h1D, 8'h00, 13)};
		plan = {plan, pkt(8'h80, 16'd0, 8'hFF, 8'h00, 13)};
		plan = {plan, pkt(8'h80, 16'd0, 8'h17, 8'h00, 13)};
		plan = {plan, pkt(8'h90, 16'd1, 8'h00, 8'h00, 20)};
		plan = {plan, wr(6'd5, 32'd5, 1'b1)};
		plan = {plan, pkt(8'h80, 16'd0, 8'h01, 8'h00, 13)};

		foreach (plan[n]) begin
			send_desc(plan[n], plan[n].len > 100);
		end

		// sender pauses until the block has drained, then the receiver holds off
		wait_for_results();
		hold_results = 1'b1;
		rand_base = items_sent;
		while (items_sent < ITEM_TOTAL) begin
			send_desc(random_desc(), $urandom_range(0, 4) == 0);
			if (!drained && items_sent > rand_base + (ITEM_TOTAL - rand_base) / 2) begin
				drained = 1'b1;
				wait_for_results();
			end
		end

		wait_for_results();
		repeat (TABLE_DEPTH + 16) @(posedge clk);
		if (fail_count == 0 && pending_verdicts.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// result side stall: random runs, calm stretches, one long hold-off
	initial begin : result_drain
		int unsigned run_left;
		int unsigned calm_left;
		int unsigned g;
		run_left = 0;
		calm_left = 0;
		forever begin
			@(posedge clk);
			if (run_left != 0) begin
				run_left--;
			end else if (hold_results) begin
				hold_results = 1'b0;
				out_stall <= 1'b1;
				run_left = 400;
			end else if (calm_left != 0) begin
				calm_left--;
				out_stall <= 1'b0;
			end else begin
				g = pick_gap();
				out_stall <= (g != 0);
				run_left = (g == 0) ? 0 : g - 1;
				if ($urandom_range(0, 99) == 0) calm_left = 200;
			end
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_verdicts.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT) begin
					$display("unexpected result: classify %0b status %0d nal_number %0d",
						classify, status, nal_number);
				end
			end else begin
				want = pending_verdicts.pop_front();
				if (classify !== want.cls || status !== want.st || nal_number !== want.num) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display({"mismatch: classify exp %0b got %0b, status exp %0d got %0d,",
							" nal_number exp %0d got %0d"},
							want.cls, classify, want.st, status, want.num, nal_number);
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
